[sv/glpm_pkg.sv]
package glpm_pkg;

  localparam int MAX_LINES_DEF    = 512;
  localparam int SERIES_CODES_DEF = 16;

  localparam int GATE_W   = 8;
  localparam int MASK_W   = 16;
  localparam int COUNT_W  = 10;
  localparam int SLOT_W   = 9;
  localparam int EN_W     = 16;
  localparam int SER_W    = 4;
  localparam int SIG_W    = 32;
  localparam int RHS_W    = 52;
  localparam int SCORE_W  = 16;
  localparam int CONF_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QAW         = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_MATCH = 1'b1;

  localparam logic [GATE_W-1:0] GATE_FACTOR_RST = 8'd16;

  // (1000*p + 1177) / 2355 reduces to (200*p + 235) / 471
  localparam logic [7:0]  FWHM_MUL     = 8'd200;
  localparam logic [7:0]  FWHM_ROUND   = 8'd235;
  localparam logic [40:0] FWHM_RECIP   = 41'd1195222831044;
  localparam int          FWHM_SHIFT   = 49;
  localparam logic [11:0] GATE_K       = 12'd2355;
  localparam logic [29:0] GATE_D_SCALE = 30'd1048576000;

  localparam int X_W = 22;
  localparam int T_W = 28;

  localparam logic [6:0]  W_EXP       = 7'd65;
  localparam logic [4:0]  W_SQRT      = 5'd25;
  localparam logic [21:0] S_DETECTED  = 22'd393216;
  localparam logic [21:0] S_PLAIN     = 22'd327680;
  localparam logic [5:0]  SCORE_ROUND = 6'd50;
  localparam logic [22:0] RECIP_100   = 23'd5368710;
  localparam int          RECIP_SHIFT = 29;

  localparam logic [SCORE_W-1:0] CONF_HI_TH = 16'd16384;
  localparam logic [SCORE_W-1:0] CONF_LO_TH = 16'd9831;
  localparam logic [CONF_W-1:0] CONF_NONE      = 2'd0;
  localparam logic [CONF_W-1:0] CONF_TENTATIVE = 2'd1;
  localparam logic [CONF_W-1:0] CONF_SURE      = 2'd2;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [EN_W-1:0]   energy;
    logic [EN_W-1:0]   yld;
    logic [SER_W-1:0]  series;
    logic [EN_W-1:0]   pe;
    logic [SIG_W-1:0]  sig;
    logic [RHS_W-1:0]  rhs;
  } cmd_t;

  typedef struct packed {
    logic [EN_W-1:0]  energy;
    logic [EN_W-1:0]  yld;
    logic [SER_W-1:0] series;
  } line_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PROD, F_SCALE, F_DIV, F_GATE, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_ADDR, B_CHECK, B_DIV, B_SQR, B_EXP, B_SUM, B_SCALE, B_CMP, B_DONE
  } back_state_t;

  // exp(-2^(k-16)) in q0.32
  function automatic logic [31:0] exp_coef(input logic [4:0] k);
    logic [31:0] c;
    case (k)
      5'd0:    c = 32'd4294901760;
      5'd1:    c = 32'd4294836226;
      5'd2:    c = 32'd4294705160;
      5'd3:    c = 32'd4294443040;
      5'd4:    c = 32'd4293918848;
      5'd5:    c = 32'd4292870656;
      5'd6:    c = 32'd4290775039;
      5'd7:    c = 32'd4286586875;
      5'd8:    c = 32'd4278222805;
      5'd9:    c = 32'd4261543595;
      5'd10:   c = 32'd4228380000;
      5'd11:   c = 32'd4162825044;
      5'd12:   c = 32'd4034748382;
      5'd13:   c = 32'd3790295335;
      5'd14:   c = 32'd3344923893;
      5'd15:   c = 32'd2605029347;
      5'd16:   c = 32'd1580030169;
      5'd17:   c = 32'd581260615;
      5'd18:   c = 32'd78665070;
      5'd19:   c = 32'd1440801;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

[sv/glpm_front.sv]
module glpm_front import glpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [SLOT_W-1:0] entry_slot,
  input  logic [EN_W-1:0]   entry_energy,
  input  logic [EN_W-1:0]   entry_yield,
  input  logic [SER_W-1:0]  entry_series,
  input  logic [EN_W-1:0]   peak_energy,
  input  logic [EN_W-1:0]   peak_sigma,
  input  logic [EN_W-1:0]   peak_fwhm,
  input  logic [EN_W-1:0]   local_slope,
  input  logic [GATE_W-1:0] gate_factor,
  input  q_stat_t           q_stat,
  output logic              push,
  output cmd_t              push_cmd
);

  front_state_t state, state_next;
  cmd_t         cmd;
  logic [EN_W-1:0]  sg, fw, sl;
  logic [31:0]      prod;
  logic [19:0]      gfk;
  logic [39:0]      num;
  logic [1:0]       pstep;
  logic [19:0]      mx_a;
  logic [20:0]      mx_m;
  logic [40:0]      pp;
  logic [79:0]      term, acc, acc_sum;

  // reciprocal multiply in four partial products
  assign mx_a    = pstep[1] ? num[39:20] : num[19:0];
  assign mx_m    = pstep[0] ? {1'b0, FWHM_RECIP[40:21]} : FWHM_RECIP[20:0];
  assign pp      = 41'(mx_a) * 41'(mx_m);
  assign acc_sum = acc + term;

  always_comb begin
    case (pstep)
      2'd0:    term = 80'(pp);
      2'd1:    term = 80'(pp) << 21;
      2'd2:    term = 80'(pp) << 20;
      default: term = 80'(pp) << 41;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (start) state_next = F_PROD;
      F_PROD:  state_next = (cmd.action == ACT_LOAD) ? F_PUSH : F_SCALE;
      F_SCALE: state_next = (sg == '0 && fw != '0) ? F_DIV : F_GATE;
      F_DIV:   if (pstep == 2'd3) state_next = F_GATE;
      F_GATE:  state_next = F_PUSH;
      F_PUSH:  if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy     = state != F_IDLE;
    push     = state == F_PUSH && !q_stat.full;
    push_cmd = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          cmd.action <= action;
          cmd.slot   <= entry_slot;
          cmd.energy <= entry_energy;
          cmd.yld    <= entry_yield;
          cmd.series <= entry_series;
          cmd.pe     <= peak_energy;
          sg <= peak_sigma;
          fw <= peak_fwhm;
          sl <= local_slope;
        end
      end
      F_PROD: begin
        prod <= 32'((sg != '0) ? sg : fw) * 32'(sl);
        gfk  <= 20'(gate_factor) * 20'(GATE_K);
      end
      F_SCALE: begin
        num     <= 40'(prod) * 40'(FWHM_MUL) + 40'(FWHM_ROUND);
        cmd.sig <= (sg != '0) ? prod : '0;
        acc     <= '0;
        pstep   <= '0;
      end
      F_DIV: begin
        acc   <= acc_sum;
        pstep <= pstep + 2'd1;
        if (pstep == 2'd3) begin
          cmd.sig <= {1'b0, acc_sum[FWHM_SHIFT+30:FWHM_SHIFT]};
        end
      end
      F_GATE: begin
        cmd.rhs <= RHS_W'(gfk) * RHS_W'(cmd.sig);
      end
      default: ;
    endcase
  end

endmodule

[sv/glpm_queue.sv]
module glpm_queue import glpm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign q_stat.full  = count == (QAW+1)'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign pop_cmd      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_cmd;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("request pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !q_stat.empty)
    else $error("request popped from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a request");
`endif

endmodule

[sv/glpm_back.sv]
module glpm_back import glpm_pkg::*; #(
  parameter int MAX_LINES    = MAX_LINES_DEF,
  parameter int SERIES_CODES = SERIES_CODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  q_stat_t            q_stat,
  input  cmd_t               q_cmd,
  output logic               pop,
  input  logic [MASK_W-1:0]  series_mask,
  input  logic [COUNT_W-1:0] line_count,
  output logic               done,
  output logic               matched,
  output logic [SLOT_W-1:0]  best_index,
  output logic [SCORE_W-1:0] best_score,
  output logic [CONF_W-1:0]  confidence
);

  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = AW + 1;

  back_state_t state, state_next;
  cmd_t        cur;
  line_t       mem [MAX_LINES];
  line_t       rd_data;
  logic [CW-1:0] idx, nlim;
  logic [AW-1:0] bidx;
  logic [SCORE_W-1:0] best;
  logic found;

  logic [EN_W-1:0]  d;
  logic [45:0]      dscaled;
  logic             pass;
  logic [47:0]      nfull;
  logic [21:0]      nsh;
  logic [31:0]      drem;
  logic [32:0]      remsh;
  logic             ge;
  logic [X_W-1:0]   xq;
  logic [4:0]       cnt;
  logic [31:0]      sq_v, sq_res, sq_bit, sq_sum;
  logic [T_W-1:0]   t;
  logic [32:0]      r;
  logic [4:0]       k;
  logic [64:0]      eprod, eround;
  logic [33:0]      rr;
  logic [15:0]      e;
  logic             ser_det;
  logic [21:0]      v;
  logic [44:0]      vprod;
  logic [SCORE_W-1:0] score;
  logic [43:0]      xsq;
  logic [44:0]      tsum;
  logic             slot_ok;

  assign nlim    = (32'(line_count) < MAX_LINES) ? CW'(line_count) : CW'(MAX_LINES);
  assign d       = (cur.pe > rd_data.energy) ? cur.pe - rd_data.energy
                                             : rd_data.energy - cur.pe;
  assign dscaled = 46'(d) * 46'(GATE_D_SCALE);
  assign pass    = {6'b0, dscaled} <= cur.rhs;
  assign nfull   = {d, 32'b0} + {17'b0, cur.sig[31:1]};
  assign remsh   = {drem, nsh[21]};
  assign ge      = remsh >= {1'b0, cur.sig};
  assign sq_sum  = sq_res + sq_bit;
  assign eprod   = 65'(r) * 65'(exp_coef(k));
  assign eround  = eprod + 65'h80000000;
  assign rr      = 34'(r) + 34'h10000;
  assign e       = (t >= T_W'(1 << 20)) ? '0 : rr[32:17];
  assign xsq     = 44'(xq) * 44'(xq);
  assign tsum    = 45'(xsq) + 45'd32768;
  assign vprod   = 45'(v) * 45'(RECIP_100);
  assign slot_ok = 32'(cur.slot) < MAX_LINES;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (q_cmd.action == ACT_LOAD)  state_next = B_LOAD;
          else if (q_cmd.sig == '0)      state_next = B_DONE;
          else                           state_next = B_ADDR;
        end
      end
      B_LOAD:  state_next = B_DONE;
      B_ADDR:  state_next = (idx == nlim) ? B_DONE : B_CHECK;
      B_CHECK: state_next = pass ? B_DIV : B_ADDR;
      B_DIV:   if (cnt == 5'd1) state_next = B_SQR;
      B_SQR:   state_next = B_EXP;
      B_EXP:   if (k == 5'd19) state_next = B_SUM;
      B_SUM:   state_next = B_SCALE;
      B_SCALE: state_next = B_CMP;
      B_CMP:   state_next = B_ADDR;
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop        = state == B_IDLE && !q_stat.empty;
    done       = state == B_DONE;
    matched    = found;
    best_index = SLOT_W'(bidx);
    best_score = best;
    if (best >= CONF_HI_TH)      confidence = CONF_SURE;
    else if (best >= CONF_LO_TH) confidence = CONF_TENTATIVE;
    else                         confidence = CONF_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD && slot_ok) begin
      mem[AW'(cur.slot)] <= '{energy: cur.energy, yld: cur.yld, series: cur.series};
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      best  <= '0;
      bidx  <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            cur   <= q_cmd;
            idx   <= '0;
            found <= 1'b0;
            best  <= '0;
            bidx  <= '0;
          end
        end
        B_CHECK: begin
          if (pass) begin
            nsh     <= nfull[21:0];
            drem    <= {6'b0, nfull[47:22]};
            xq      <= '0;
            cnt     <= 5'd22;
            sq_v    <= {2'b0, rd_data.yld, 14'b0};
            sq_res  <= '0;
            sq_bit  <= 32'h40000000;
            ser_det <= (32'(rd_data.series) < SERIES_CODES) && series_mask[rd_data.series];
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_DIV: begin
          drem <= ge ? 32'(remsh - {1'b0, cur.sig}) : remsh[31:0];
          nsh  <= {nsh[20:0], 1'b0};
          xq   <= {xq[X_W-2:0], ge};
          cnt  <= cnt - 5'd1;
          if (sq_bit != '0) begin
            if (sq_v >= sq_sum) begin
              sq_v   <= sq_v - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        B_SQR: begin
          t <= tsum[T_W+15:16];
          r <= 33'h100000000;
          k <= '0;
        end
        B_EXP: begin
          if (t[k]) r <= eround[64:32];
          k <= k + 5'd1;
        end
        B_SUM: begin
          v <= 22'(e) * 22'(W_EXP) + 22'(sq_res[15:0]) * 22'(W_SQRT)
             + (ser_det ? S_DETECTED : S_PLAIN) + 22'(SCORE_ROUND);
        end
        B_SCALE: begin
          score <= vprod[RECIP_SHIFT+SCORE_W-1:RECIP_SHIFT];
        end
        B_CMP: begin
          if (score > best) begin
            best  <= score;
            bidx  <= idx[AW-1:0];
            found <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_clear_on_miss: assert property (@(posedge clk) disable iff (rst)
      (done && !matched) |-> (best_score == '0 && confidence == CONF_NONE))
    else $error("unmatched request carries a score");
  a_conf_class: assert property (@(posedge clk) disable iff (rst)
      (done && matched) |-> ((confidence == CONF_SURE) == (best_score >= CONF_HI_TH)))
    else $error("confidence class disagrees with score");
  a_single_result: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule

[sv/gamma_line_peak_matcher.sv]
// Gamma line peak matcher. A request with start high is taken while busy is low; every
// request gives exactly one result, shown for a single cycle with done high, and the
// receiver cannot stall it. A load request writes one table entry if its slot lies within
// the table. A match request first runs its setup in the front (when sigma comes from the
// FWHM, it is set by a four-step reciprocal multiply for the divide by 2355), then walks
// the table one entry at a time through a single read port: an entry outside the energy
// gate is only read and checked, one inside it also goes through a 22-step divide, a
// 20-step exponent and scoring. A match request whose sigma is zero skips the walk.
// The front accepts a new request as soon as its setup is done and a two-deep queue has
// room, so busy drops while the back still walks the table of an earlier request.
module gamma_line_peak_matcher import glpm_pkg::*; #(
  parameter int MAX_LINES    = MAX_LINES_DEF,
  parameter int SERIES_CODES = SERIES_CODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  action,
  input  logic [SLOT_W-1:0]     entry_slot,
  input  logic [EN_W-1:0]       entry_energy,
  input  logic [EN_W-1:0]       entry_yield,
  input  logic [SER_W-1:0]      entry_series,
  input  logic [EN_W-1:0]       peak_energy,
  input  logic [EN_W-1:0]       peak_sigma,
  input  logic [EN_W-1:0]       peak_fwhm,
  input  logic [EN_W-1:0]       local_slope,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic                  matched,
  output logic [SLOT_W-1:0]     best_index,
  output logic [SCORE_W-1:0]    best_score,
  output logic [CONF_W-1:0]     confidence
);

  logic [GATE_W-1:0]  gate_factor;
  logic [MASK_W-1:0]  series_mask;
  logic [COUNT_W-1:0] line_count;
  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_factor <= GATE_FACTOR_RST;
      series_mask <= '0;
      line_count  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GATE_FACTOR: gate_factor <= cfg_data[GATE_W-1:0];
        CFG_SERIES_MASK: series_mask <= cfg_data[MASK_W-1:0];
        CFG_LINE_COUNT:  line_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  glpm_front u_front (
    .clk, .rst, .start, .busy, .action, .entry_slot, .entry_energy, .entry_yield,
    .entry_series, .peak_energy, .peak_sigma, .peak_fwhm, .local_slope,
    .gate_factor, .q_stat, .push, .push_cmd
  );

  glpm_queue u_queue (
    .clk, .rst, .push, .push_cmd, .pop, .pop_cmd, .q_stat
  );

  glpm_back #(
    .MAX_LINES(MAX_LINES),
    .SERIES_CODES(SERIES_CODES)
  ) u_back (
    .clk, .rst, .q_stat, .q_cmd(pop_cmd), .pop, .series_mask, .line_count,
    .done, .matched, .best_index, .best_score, .confidence
  );

endmodule
